// ===== rtl/lgs_pkg.sv =====
// ----------------------------------------------------------------------------
// lgs_pkg
// Shared constants and types for the life grid generation step core.
// ----------------------------------------------------------------------------
package lgs_pkg;

  localparam int MAX_COLS = 64;
  localparam int MAX_ROWS = 64;
  localparam int COL_W    = $clog2(MAX_COLS);
  localparam int ROW_W    = $clog2(MAX_ROWS);
  localparam int SIZE_W   = 7;

  // item kinds
  localparam logic [1:0] FUNC_WRITE = 2'd0;
  localparam logic [1:0] FUNC_READ  = 2'd1;
  localparam logic [1:0] FUNC_STEP  = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_HEIGHT = 2'd1;

  typedef logic [MAX_COLS-1:0] row_t;

  typedef struct packed {
    logic             en;
    logic [ROW_W-1:0] addr;
  } row_rd_t;

  typedef struct packed {
    logic             en;
    logic [ROW_W-1:0] addr;
    row_t             data;
  } row_wr_t;

endpackage

// ===== rtl/lgs_row_store.sv =====
// ----------------------------------------------------------------------------
// lgs_row_store
// Cell grid held as one row per memory word, with a valid bit per row.
// ----------------------------------------------------------------------------
module lgs_row_store (
  input  logic             clk,
  input  logic             rst,
  input  lgs_pkg::row_rd_t rd,
  input  lgs_pkg::row_wr_t wr,
  output lgs_pkg::row_t    rd_row
);

  lgs_pkg::row_t                 mem [lgs_pkg::MAX_ROWS];
  logic [lgs_pkg::MAX_ROWS-1:0]  row_valid;
  lgs_pkg::row_t                 rd_q;
  logic                          rd_valid_q;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd.en) begin
      rd_q <= mem[rd.addr];
    end
  end

  // a row never written since reset reads as all dead
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid  <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr.en) begin
        row_valid[wr.addr] <= 1'b1;
      end
      if (rd.en) begin
        rd_valid_q <= row_valid[rd.addr];
      end
    end
  end

  assign rd_row = rd_valid_q ? rd_q : '0;

endmodule

// ===== rtl/lgs_cell_rule.sv =====
// ----------------------------------------------------------------------------
// lgs_cell_rule
// Neighbor count and survival rule for one cell of a 3x3 window.
// ----------------------------------------------------------------------------
module lgs_cell_rule (
  input  logic [2:0] up_win,   // bit 0 left, bit 1 center, bit 2 right
  input  logic [2:0] mid_win,
  input  logic [2:0] dn_win,
  output logic       next_cell
);

  logic [3:0] count;

  always_comb begin
    count = 4'(up_win[0]) + 4'(up_win[1]) + 4'(up_win[2])
          + 4'(mid_win[0]) + 4'(mid_win[2])
          + 4'(dn_win[0]) + 4'(dn_win[1]) + 4'(dn_win[2]);
    if (mid_win[1]) begin
      next_cell = (count == 4'd2) || (count == 4'd3);
    end else begin
      next_cell = (count == 4'd3);
    end
  end

endmodule

// ===== rtl/life_grid_generation_step_core.sv =====
// ----------------------------------------------------------------------------
// life_grid_generation_step_core
// Game of Life grid with cell read, cell write and one-generation step items.
// ----------------------------------------------------------------------------
// The core keeps a 64 x 64 one-bit cell grid, all dead after reset (reset
// takes effect at once; no clearing sweep). grid_width and grid_height select
// the part in use (values above 64 act as 64, zero leaves no cell in use).
// Each input item writes a cell, reads a cell or advances one generation, and
// yields exactly one result item: cell_out (the cell read, else 0) and
// bad_coordinate (read or write outside the part in use; access dropped).
// Cells beyond the edges count as dead and cells outside the part in use are
// neither counted nor changed. The core takes one item at a time. A read or
// write item passes through a read-modify-write state (skipped when the
// coordinate is bad or the item code is unused), and a step item sweeps the
// part in use row by row: a single neighbor-count unit evaluates one cell per
// cycle and each row costs one memory fetch, one window load and one
// write-back. A finished result sits in an output register, so the next item
// is accepted while it waits; a second finished result holds the core until
// the first one leaves. Write configuration only while idle.
// ----------------------------------------------------------------------------
module life_grid_generation_step_core (
  input  logic        clk,
  input  logic        rst,
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [6:0]  cfg_data,
  // item input
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [1:0]  s_axis_tuser,   // func[1:0]
  input  logic [15:0] s_axis_tdata,   // column[5:0], row_index[11:6], cell_in[12]
  // result output
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata    // cell_out[0], bad_coordinate[1]
);

  localparam int COL_W  = lgs_pkg::COL_W;
  localparam int ROW_W  = lgs_pkg::ROW_W;
  localparam int SIZE_W = lgs_pkg::SIZE_W;

  // sequencer codes
  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_RMW     = 3'd1;
  localparam logic [2:0] S_LOADMID = 3'd2;
  localparam logic [2:0] S_FETCH   = 3'd3;
  localparam logic [2:0] S_LOADDN  = 3'd4;
  localparam logic [2:0] S_CELL    = 3'd5;
  localparam logic [2:0] S_WB      = 3'd6;
  localparam logic [2:0] S_DONE    = 3'd7;

  logic [2:0]        state;
  logic [SIZE_W-1:0] grid_width;
  logic [SIZE_W-1:0] grid_height;
  logic [SIZE_W-1:0] cols_used;
  logic [SIZE_W-1:0] rows_used;

  // latched item
  logic [1:0]        func_q;
  logic [COL_W-1:0]  col_q;
  logic [ROW_W-1:0]  row_q;
  logic              val_q;

  // unpacked input fields
  logic [1:0]        in_func;
  logic [COL_W-1:0]  in_col;
  logic [ROW_W-1:0]  in_row;
  logic              in_val;
  logic              in_acc;
  logic              in_bad;

  // step sweep
  logic [ROW_W-1:0]  row_cnt;
  logic [COL_W-1:0]  col_cnt;
  logic [SIZE_W-1:0] row_plus1;
  logic [SIZE_W-1:0] col_plus1;
  lgs_pkg::row_t     up_row;
  lgs_pkg::row_t     mid_row;
  lgs_pkg::row_t     dn_row;
  lgs_pkg::row_t     new_row;
  logic [COL_W-1:0]  col_left;
  logic [COL_W-1:0]  col_right;
  logic              has_left;
  logic              has_right;
  logic [2:0]        up_win;
  logic [2:0]        mid_win;
  logic [2:0]        dn_win;
  logic              next_cell;

  // result
  logic              res_cell;
  logic              res_bad;
  logic              out_valid;
  logic              out_cell;
  logic              out_bad;
  logic              out_load;

  lgs_pkg::row_rd_t  rd;
  lgs_pkg::row_wr_t  wr;
  lgs_pkg::row_t     rd_row;
  lgs_pkg::row_t     rmw_row;

  assign in_func = s_axis_tuser;
  assign in_col  = s_axis_tdata[5:0];
  assign in_row  = s_axis_tdata[11:6];
  assign in_val  = s_axis_tdata[12];

  assign s_axis_tready = (state == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready     = 1'b1;

  // clamp the configured size to the grid
  assign cols_used = (grid_width  > SIZE_W'(lgs_pkg::MAX_COLS)) ?
                     SIZE_W'(lgs_pkg::MAX_COLS) : grid_width;
  assign rows_used = (grid_height > SIZE_W'(lgs_pkg::MAX_ROWS)) ?
                     SIZE_W'(lgs_pkg::MAX_ROWS) : grid_height;

  assign in_bad = ({1'b0, in_col} >= cols_used) || ({1'b0, in_row} >= rows_used);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= SIZE_W'(lgs_pkg::MAX_COLS);
      grid_height <= SIZE_W'(lgs_pkg::MAX_ROWS);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        lgs_pkg::CFG_WIDTH:  grid_width  <= cfg_data;
        lgs_pkg::CFG_HEIGHT: grid_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // 3x3 window around the current column; edges and unused columns read dead
  assign row_plus1 = {1'b0, row_cnt} + SIZE_W'(1);
  assign col_plus1 = {1'b0, col_cnt} + SIZE_W'(1);
  assign col_left  = col_cnt - COL_W'(1);
  assign col_right = col_cnt + COL_W'(1);
  assign has_left  = (col_cnt != '0);
  assign has_right = (col_plus1 < cols_used);

  assign up_win  = {has_right & up_row[col_right],  up_row[col_cnt],
                    has_left & up_row[col_left]};
  assign mid_win = {has_right & mid_row[col_right], mid_row[col_cnt],
                    has_left & mid_row[col_left]};
  assign dn_win  = {has_right & dn_row[col_right],  dn_row[col_cnt],
                    has_left & dn_row[col_left]};

  lgs_cell_rule u_rule (
    .up_win    (up_win),
    .mid_win   (mid_win),
    .dn_win    (dn_win),
    .next_cell (next_cell)
  );

  // memory requests
  always_comb begin
    rmw_row        = rd_row;
    rmw_row[col_q] = val_q;

    rd = '0;
    wr = '0;
    unique case (state)
      S_IDLE: begin
        rd.en   = in_acc && !in_bad &&
                  ((in_func == lgs_pkg::FUNC_WRITE) || (in_func == lgs_pkg::FUNC_READ));
        rd.addr = in_row;
        if (in_acc && (in_func == lgs_pkg::FUNC_STEP)) begin
          rd.en   = 1'b1;
          rd.addr = '0;
        end
      end
      S_RMW: begin
        wr.en   = (func_q == lgs_pkg::FUNC_WRITE);
        wr.addr = row_q;
        wr.data = rmw_row;
      end
      S_FETCH: begin
        rd.en   = 1'b1;
        rd.addr = row_plus1[ROW_W-1:0];
      end
      S_WB: begin
        wr.en   = 1'b1;
        wr.addr = row_cnt;
        wr.data = new_row;
      end
      default: ;
    endcase
  end

  lgs_row_store u_store (
    .clk    (clk),
    .rst    (rst),
    .rd     (rd),
    .wr     (wr),
    .rd_row (rd_row)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            if ((in_func == lgs_pkg::FUNC_WRITE) || (in_func == lgs_pkg::FUNC_READ)) begin
              state <= in_bad ? S_DONE : S_RMW;
            end else if (in_func == lgs_pkg::FUNC_STEP) begin
              state <= ((cols_used == '0) || (rows_used == '0)) ? S_DONE : S_LOADMID;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_RMW:     state <= S_DONE;
        S_LOADMID: state <= S_FETCH;
        S_FETCH:   state <= S_LOADDN;
        S_LOADDN:  state <= S_CELL;
        S_CELL: begin
          if (col_plus1 == cols_used) begin
            state <= S_WB;
          end
        end
        S_WB: begin
          state <= (row_plus1 == rows_used) ? S_DONE : S_FETCH;
        end
        S_DONE: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        func_q   <= in_func;
        col_q    <= in_col;
        row_q    <= in_row;
        val_q    <= in_val;
        row_cnt  <= '0;
        res_cell <= 1'b0;
        res_bad  <= in_bad &&
                    ((in_func == lgs_pkg::FUNC_WRITE) || (in_func == lgs_pkg::FUNC_READ));
      end
      S_RMW: begin
        if (func_q == lgs_pkg::FUNC_READ) begin
          res_cell <= rd_row[col_q];
        end
      end
      S_LOADMID: begin
        up_row  <= '0;
        mid_row <= rd_row;
      end
      S_LOADDN: begin
        // below the last row in use counts as dead
        dn_row  <= (row_plus1 < rows_used) ? rd_row : '0;
        new_row <= mid_row;
        col_cnt <= '0;
      end
      S_CELL: begin
        new_row[col_cnt] <= next_cell;
        col_cnt          <= col_plus1[COL_W-1:0];
      end
      S_WB: begin
        // slide the window down; the old rows stay in registers
        up_row  <= mid_row;
        mid_row <= dn_row;
        row_cnt <= row_plus1[ROW_W-1:0];
      end
      default: ;
    endcase
  end

  // output register
  assign out_load = (state == S_DONE) && (!out_valid || m_axis_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_cell <= res_cell;
      out_bad  <= res_bad;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {6'd0, out_bad, out_cell};

  // checks
  a_read_bad_is_dead: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[1]))
    else $error("bad coordinate reported with a live cell");

  a_col_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_CELL) |-> ({1'b0, col_cnt} < cols_used))
    else $error("column counter left the grid in use");

  a_row_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_CELL || state == S_WB || state == S_FETCH) |->
      ({1'b0, row_cnt} < rows_used))
    else $error("row counter left the grid in use");

  a_write_origin: assert property (@(posedge clk) disable iff (rst)
    wr.en |-> (state == S_RMW || state == S_WB))
    else $error("store written outside an update step");

  a_result_follows_done: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(state) == S_DONE)
    else $error("result raised without a finished item");

endmodule

// ===== dv/life_grid_generation_step_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// life_grid_generation_step_core_tb
// Self-checking bench for the Game of Life grid core.
// ----------------------------------------------------------------------------
// Drives cell writes, cell reads, generation steps and the unused item code
// into the core. A behavioral copy of the grid predicts every result item, and
// a checker compares each result with the oldest prediction. The grid size
// registers move through several settings, including zero and values above
// the grid maximum, and both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module life_grid_generation_step_core_tb;

  // item code with no function, and a register index past the list
  localparam logic [1:0] FUNC_NOP = 2'd3;
  localparam logic [1:0] CFG_NONE = 2'd3;
  localparam logic [1:0] CFG_GAP  = 2'd2;
  // longest quiet stretch: must outlast a full-size step and a long stall
  localparam int QUIET_LIMIT = 20000;

  typedef struct packed {
    logic alive;
    logic bad;
  } cell_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [6:0]  cfg_data = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [1:0]  s_axis_tuser = '0;   // func[1:0]
  logic [15:0] s_axis_tdata = '0;   // column[5:0], row_index[11:6], cell_in[12]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;        // cell_out[0], bad_coordinate[1]

  // predicted grid: one word per row, bit index is the column
  logic [lgs_pkg::MAX_COLS-1:0] cell_grid [lgs_pkg::MAX_ROWS];
  logic [6:0]                   width_reg = 7'd64;
  logic [6:0]                   height_reg = 7'd64;
  cell_result_t                 expected_cells [$];

  int mismatch_count = 0;
  int quiet_cycles = 0;
  bit source_idle_on = 1'b0;
  bit sink_idle_on = 1'b0;
  int long_hold_len = 0;
  int long_hold_seq = 0;

  life_grid_generation_step_core dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Grid prediction
  // --------------------------------------------------------------------------
  // Sizes above the grid maximum act as the maximum.
  function automatic int live_cols();
    return (width_reg > lgs_pkg::MAX_COLS) ? lgs_pkg::MAX_COLS : int'(width_reg);
  endfunction

  function automatic int live_rows();
    return (height_reg > lgs_pkg::MAX_ROWS) ? lgs_pkg::MAX_ROWS : int'(height_reg);
  endfunction

  // Apply one item to the grid copy and return the result it must produce.
  function automatic cell_result_t apply_cell_item(logic [1:0] func, logic [5:0] col,
                                                   logic [5:0] row, logic cell_val);
    cell_result_t                 res;
    int                           w;
    int                           h;
    int                           n;
    logic [lgs_pkg::MAX_COLS-1:0] next_rows [lgs_pkg::MAX_ROWS];
    res = '0;
    w = live_cols();
    h = live_rows();
    case (func)
      lgs_pkg::FUNC_WRITE, lgs_pkg::FUNC_READ: begin
        if (int'(col) >= w || int'(row) >= h) begin
          res.bad = 1'b1;
        end else if (func == lgs_pkg::FUNC_WRITE) begin
          cell_grid[row][col] = cell_val;
        end else begin
          res.alive = cell_grid[row][col];
        end
      end
      lgs_pkg::FUNC_STEP: begin
        // count from the old grid, then commit the whole part in use at once
        for (int r = 0; r < h; r++) begin
          for (int c = 0; c < w; c++) begin
            n = 0;
            for (int dr = -1; dr <= 1; dr++) begin
              for (int dc = -1; dc <= 1; dc++) begin
                if ((dr != 0 || dc != 0) && r + dr >= 0 && r + dr < h &&
                    c + dc >= 0 && c + dc < w)
                  n += cell_grid[r + dr][c + dc];
              end
            end
            next_rows[r][c] = cell_grid[r][c] ? (n == 2 || n == 3) : (n == 3);
          end
        end
        for (int r = 0; r < h; r++)
          for (int c = 0; c < w; c++)
            cell_grid[r][c] = next_rows[r][c];
      end
      default: ;
    endcase
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------
  // Mostly short gaps, now and then a long one.
  function automatic int random_gap();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 80) return $urandom_range(1, 3);
    if (pick < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Offer one item, hold it until accepted, then record its predicted result.
  task automatic send_cell_item(logic [1:0] func, logic [5:0] col, logic [5:0] row,
                                logic cell_val);
    int gap;
    gap = (source_idle_on && $urandom_range(0, 2) == 0) ? random_gap() : 0;
    if (gap > 0) begin
      @(negedge clk);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= func;
    s_axis_tdata  <= {3'b0, cell_val, row, col};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    expected_cells.push_back(apply_cell_item(func, col, row, cell_val));
  endtask

  // Drop valid and hold until every predicted result has come back.
  task automatic wait_for_results();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (expected_cells.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_size_reg(logic [1:0] idx, logic [6:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == lgs_pkg::CFG_WIDTH) width_reg = value;
    else if (idx == lgs_pkg::CFG_HEIGHT) height_reg = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Resize only once the core is idle.
  task automatic set_grid_size(logic [6:0] cols, logic [6:0] rows);
    wait_for_results();
    write_size_reg(lgs_pkg::CFG_WIDTH, cols);
    write_size_reg(lgs_pkg::CFG_HEIGHT, rows);
  endtask

  // Result side: random stalls, plus a long hold-off whenever a test asks.
  initial begin : result_sink
    int stall_left;
    int seen_seq;
    stall_left = 0;
    seen_seq = 0;
    forever begin
      @(negedge clk);
      if (long_hold_seq != seen_seq) begin
        seen_seq = long_hold_seq;
        stall_left = long_hold_len;
      end
      if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
        if (sink_idle_on && $urandom_range(0, 3) == 0) stall_left = random_gap();
      end
    end
  end

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------
  // Compare each result with the oldest prediction; report the first batch.
  always @(posedge clk) begin : result_check
    cell_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_cells.size() == 0) begin
        if (mismatch_count < 64)
          $display("%0t: unexpected result item, expected none, actual cell_out %0d bad %0d",
                   $time, m_axis_tdata[0], m_axis_tdata[1]);
        mismatch_count++;
      end else begin
        want = expected_cells.pop_front();
        if (m_axis_tdata[0] !== want.alive) begin
          if (mismatch_count < 64)
            $display("%0t: cell_out mismatch, expected %0d, actual %0d",
                     $time, want.alive, m_axis_tdata[0]);
          mismatch_count++;
        end
        if (m_axis_tdata[1] !== want.bad) begin
          if (mismatch_count < 64)
            $display("%0t: bad_coordinate mismatch, expected %0d, actual %0d",
                     $time, want.bad, m_axis_tdata[1]);
          mismatch_count++;
        end
      end
    end
  end

  // End the run if nothing moves on any channel for too long.
  always @(posedge clk) begin : stall_watchdog
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("%0t: no item moved for %0d cycles", $time, QUIET_LIMIT);
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Corners, both cell values, a blinker with a birth, lone cells dying.
  task automatic test_directed_cells();
    send_cell_item(lgs_pkg::FUNC_READ, 6'd0, 6'd0, 1'b0);
    send_cell_item(lgs_pkg::FUNC_READ, 6'd63, 6'd63, 1'b1);
    send_cell_item(lgs_pkg::FUNC_WRITE, 6'd63, 6'd63, 1'b1);
    send_cell_item(lgs_pkg::FUNC_WRITE, 6'd0, 6'd0, 1'b1);
    send_cell_item(lgs_pkg::FUNC_WRITE, 6'd63, 6'd0, 1'b1);
    send_cell_item(lgs_pkg::FUNC_WRITE, 6'd0, 6'd63, 1'b1);
    send_cell_item(lgs_pkg::FUNC_READ, 6'd63, 6'd63, 1'b0);
    send_cell_item(lgs_pkg::FUNC_READ, 6'd0, 6'd0, 1'b0);
    send_cell_item(lgs_pkg::FUNC_READ, 6'd63, 6'd0, 1'b0);
    send_cell_item(lgs_pkg::FUNC_READ, 6'd0, 6'd63, 1'b0);
    // clear a live cell again
    send_cell_item(lgs_pkg::FUNC_WRITE, 6'd0, 6'd0, 1'b0);
    send_cell_item(lgs_pkg::FUNC_READ, 6'd0, 6'd0, 1'b1);
    // horizontal blinker on row 20
    send_cell_item(lgs_pkg::FUNC_WRITE, 6'd30, 6'd20, 1'b1);
    send_cell_item(lgs_pkg::FUNC_WRITE, 6'd31, 6'd20, 1'b1);
    send_cell_item(lgs_pkg::FUNC_WRITE, 6'd32, 6'd20, 1'b1);
    // step fields other than func carry junk
    send_cell_item(lgs_pkg::FUNC_STEP, 6'h2a, 6'h15, 1'b1);
    send_cell_item(lgs_pkg::FUNC_READ, 6'd31, 6'd19, 1'b0);
    send_cell_item(lgs_pkg::FUNC_READ, 6'd31, 6'd20, 1'b0);
    send_cell_item(lgs_pkg::FUNC_READ, 6'd31, 6'd21, 1'b0);
    send_cell_item(lgs_pkg::FUNC_READ, 6'd30, 6'd20, 1'b0);
    send_cell_item(lgs_pkg::FUNC_READ, 6'd63, 6'd63, 1'b0);
    send_cell_item(FUNC_NOP, 6'd63, 6'd63, 1'b1);
    send_cell_item(lgs_pkg::FUNC_READ, 6'd63, 6'd0, 1'b0);
  endtask

  // Zero size, oversize, one-cell grid, out-of-list register, hidden cells.
  task automatic test_size_extremes();
    send_cell_item(lgs_pkg::FUNC_WRITE, 6'd40, 6'd40, 1'b1);
    set_grid_size(7'd8, 7'd8);
    send_cell_item(lgs_pkg::FUNC_READ, 6'd40, 6'd40, 1'b0);
    send_cell_item(lgs_pkg::FUNC_WRITE, 6'd8, 6'd3, 1'b1);
    send_cell_item(lgs_pkg::FUNC_STEP, 6'd0, 6'd0, 1'b0);
    set_grid_size(7'd0, 7'd5);
    send_cell_item(lgs_pkg::FUNC_WRITE, 6'd0, 6'd0, 1'b1);
    send_cell_item(lgs_pkg::FUNC_READ, 6'd0, 6'd0, 1'b0);
    send_cell_item(lgs_pkg::FUNC_STEP, 6'd0, 6'd0, 1'b0);
    set_grid_size(7'd5, 7'd0);
    send_cell_item(lgs_pkg::FUNC_READ, 6'd1, 6'd0, 1'b0);
    set_grid_size(7'd127, 7'd127);
    send_cell_item(lgs_pkg::FUNC_READ, 6'd40, 6'd40, 1'b0);
    send_cell_item(lgs_pkg::FUNC_WRITE, 6'd63, 6'd63, 1'b1);
    send_cell_item(lgs_pkg::FUNC_READ, 6'd63, 6'd63, 1'b0);
    set_grid_size(7'd1, 7'd1);
    send_cell_item(lgs_pkg::FUNC_WRITE, 6'd0, 6'd0, 1'b1);
    send_cell_item(lgs_pkg::FUNC_READ, 6'd1, 6'd0, 1'b0);
    send_cell_item(lgs_pkg::FUNC_READ, 6'd0, 6'd1, 1'b0);
    send_cell_item(lgs_pkg::FUNC_STEP, 6'd0, 6'd0, 1'b0);
    send_cell_item(lgs_pkg::FUNC_READ, 6'd0, 6'd0, 1'b0);
    // indexes past the list must leave the size alone
    wait_for_results();
    write_size_reg(CFG_NONE, 7'd5);
    write_size_reg(CFG_GAP, 7'd0);
    send_cell_item(lgs_pkg::FUNC_READ, 6'd1, 6'd1, 1'b0);
    set_grid_size(7'd64, 7'd64);
    send_cell_item(lgs_pkg::FUNC_READ, 6'd40, 6'd40, 1'b0);
  endtask

  // Random cell traffic across a series of grid sizes.
  task automatic test_random_life(int items_per_phase);
    int unsigned cols_list [$] = '{8, 5, 3, 16, 1, 12, 64, 2, 10, 64};
    int unsigned rows_list [$] = '{8, 7, 3, 4, 9, 1, 2, 64, 10, 64};
    int counted;
    int pick;
    int w;
    int h;
    for (int p = 0; p < cols_list.size(); p++) begin
      set_grid_size(7'(cols_list[p]), 7'(rows_list[p]));
      // vary the idling so some phases run back to back
      source_idle_on = (p % 3 != 2);
      sink_idle_on = (p % 3 != 1);
      w = live_cols();
      h = live_rows();
      counted = 0;
      while (counted < items_per_phase) begin
        pick = $urandom_range(0, 99);
        counted++;
        if (pick < 45)
          send_cell_item(lgs_pkg::FUNC_WRITE, 6'($urandom_range(0, w - 1)),
                         6'($urandom_range(0, h - 1)), 1'($urandom_range(0, 9) < 4));
        else if (pick < 80)
          send_cell_item(lgs_pkg::FUNC_READ, 6'($urandom_range(0, w - 1)),
                         6'($urandom_range(0, h - 1)), 1'($urandom));
        else if (pick < 88)
          send_cell_item(lgs_pkg::FUNC_STEP, 6'($urandom), 6'($urandom), 1'($urandom));
        else if (pick < 96)
          send_cell_item(2'($urandom_range(0, 1)), 6'($urandom), 6'($urandom),
                         1'($urandom));
        else begin
          // ignored item: does not count toward the phase
          send_cell_item(FUNC_NOP, 6'($urandom), 6'($urandom), 1'($urandom));
          counted--;
        end
      end
    end
  endtask

  // Hold the result side off long enough that the core stalls its input.
  task automatic test_backpressure();
    set_grid_size(7'd16, 7'd16);
    source_idle_on = 1'b0;
    sink_idle_on = 1'b0;
    @(negedge clk);
    long_hold_len = 400;
    long_hold_seq = long_hold_seq + 1;
    for (int i = 0; i < 20; i++)
      send_cell_item(2'($urandom_range(0, 1)), 6'($urandom_range(0, 15)),
                     6'($urandom_range(0, 15)), 1'($urandom));
    // pause the sender until the core has fully drained
    wait_for_results();
    for (int i = 0; i < 6; i++)
      send_cell_item(lgs_pkg::FUNC_READ, 6'($urandom_range(0, 15)),
                     6'($urandom_range(0, 15)), 1'b0);
  endtask

  initial begin : run_tests
    for (int r = 0; r < lgs_pkg::MAX_ROWS; r++) cell_grid[r] = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed_cells();
    test_size_extremes();
    test_backpressure();
    test_random_life(48);

    wait_for_results();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
